>>> rtl/assert_macros.svh
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cba_pkg.sv
// shared types, widths and codes of the contiguous bucket allocator
package cba_pkg;

    // default size of the bucket row
    localparam int NUM_BUCKETS_DEF = 256;

    // field widths
    localparam int BB_W       = 13;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 21;
    localparam int FS_W       = 8;
    localparam int START_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 1'd1;

    // register reset values
    localparam logic [BB_W-1:0]   BB_RESET   = 13'd64;
    localparam logic [ADDR_W-1:0] BASE_RESET = 32'd0;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd3;

    // request beat
    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] request_bytes;
        logic [FS_W-1:0]   free_start;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start_bucket;
        logic [ADDR_W-1:0]   address;
        logic [COUNT_W-1:0]  buckets_taken;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic                load;
        logic                clr_step;
        logic                scan_step;
        logic                mark_step;
        logic                free_step;
        logic                calc_addr;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic req_op;
        logic req_zero;
        logic req_bad;
        logic idx_last;
        logic scan_fit;
        logic mark_last;
        logic free_match;
        logic count_zero;
        logic out_space;
    } sts_t;

endpackage

>>> rtl/cba_ram.sv
// generic single write port, single read port ram with registered read
module cba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cba_ctrl.sv
// sequencing state machine of the contiguous bucket allocator
`include "assert_macros.svh"

module cba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cba_pkg::sts_t sts,
    output cba_pkg::cmd_t cmd
);
    import cba_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_MARK  = 7'b0001000,
        S_FREE  = 7'b0010000,
        S_MULT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [6:0] cmd_vec;

    // state register, clearing pass starts after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.req_op == OP_ALLOC)
                    begin
                        if (sts.req_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_ZERO;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (sts.req_bad)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FREE;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_fit)
                begin
                    state_next = S_MARK;
                end
                else if (sts.idx_last)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NO_ROOM;
                    state_next      = S_DONE;
                end
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (sts.mark_last)
                begin
                    state_next = S_MULT;
                end
            end
            S_FREE:
            begin
                cmd.free_step = 1'b1;
                if (!sts.free_match)
                begin
                    if (sts.count_zero)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MULT;
                    end
                end
                else if (sts.idx_last)
                begin
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                cmd.calc_addr   = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_space)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // datapath step commands gathered for checking
    assign cmd_vec = {cmd.load, cmd.clr_step, cmd.scan_step, cmd.mark_step,
                      cmd.free_step, cmd.calc_addr, cmd.out_load};

    `ASSERT_ALWAYS(a_one_step, clk, rst_n, $onehot0(cmd_vec), "more than one datapath step")
    `ASSERT_NEXT(a_load_busy, clk, rst_n, cmd.load, !in_ready, "ready high right after a request")

endmodule

>>> rtl/cba_datapath.sv
// owner map, scan counters, config registers and result register
`include "assert_macros.svh"

module cba_datapath #(
    parameter int NUM_BUCKETS = cba_pkg::NUM_BUCKETS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cba_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  cba_pkg::in_item_t                in_data,
    input  cba_pkg::cmd_t                    cmd,
    output cba_pkg::sts_t                    sts,
    output logic                             out_valid,
    input  logic                             out_ready,
    output cba_pkg::out_item_t               out_data
);
    import cba_pkg::*;

    localparam int IDX_W  = $clog2(NUM_BUCKETS);
    localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
    localparam int ENT_W  = IDX_W + 1;
    localparam int CAP_W  = SIZE_W + 1;
    localparam int PROD_W = IDX_W + BB_W;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_BUCKETS - 1);
    localparam logic [31:0]      NB_U     = 32'(NUM_BUCKETS);

    // configuration
    logic [BB_W-1:0]     bb_reg, bb_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    // request and scan state
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    // result register
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;
    // map access
    logic                mem_we;
    logic [ENT_W-1:0]    mem_wdata;
    logic [ENT_W-1:0]    mem_rdata;
    logic                rd_valid;
    logic [IDX_W-1:0]    rd_owner;
    logic [IDX_W-1:0]    fs_idx;
    logic [CNT_W-1:0]    run_inc;
    logic [CAP_W-1:0]    cap_add;
    logic                scan_fit;
    logic                free_match;

    // owner map: valid bit over start index of the owning run
    cba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_BUCKETS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg[IDX_W-1:0]),
        .wdata (mem_wdata),
        .raddr (idx_next[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    // decode of the entry under the scan pointer
    assign rd_valid   = mem_rdata[ENT_W-1];
    assign rd_owner   = mem_rdata[IDX_W-1:0];
    assign fs_idx     = IDX_W'(in_data.free_start);
    assign run_inc    = run_reg + CNT_W'(1);
    assign cap_add    = (run_reg == '0) ? CAP_W'(bb_reg) : cap_reg + CAP_W'(bb_reg);
    assign scan_fit   = !rd_valid && (cap_add >= CAP_W'(size_reg));
    assign free_match = rd_valid && (rd_owner == start_reg);

    // status to the controller
    always_comb
    begin
        sts.req_op     = in_data.operation;
        sts.req_zero   = (in_data.request_bytes == '0);
        sts.req_bad    = (32'(in_data.free_start) >= NB_U);
        sts.idx_last   = (idx_reg == LAST_IDX);
        sts.scan_fit   = scan_fit;
        sts.mark_last  = (idx_reg[IDX_W-1:0] == start_reg);
        sts.free_match = free_match;
        sts.count_zero = (run_reg == '0);
        sts.out_space  = !out_valid_reg || out_ready;
    end

    // configuration writes
    always_comb
    begin
        bb_next   = bb_reg;
        base_next = base_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BUCKET_BYTES: bb_next   = cfg_data[BB_W-1:0];
                REG_REGION_BASE:  base_next = cfg_data[ADDR_W-1:0];
                default:          bb_next   = bb_reg;
            endcase
        end
    end

    // request load, scan, mark, free and clearing steps, address product and status
    always_comb
    begin
        idx_next    = idx_reg;
        run_next    = run_reg;
        cap_next    = cap_reg;
        start_next  = start_reg;
        size_next   = size_reg;
        status_next = status_reg;
        prod_next   = prod_reg;
        mem_we      = 1'b0;
        mem_wdata   = '0;
        if (cmd.load)
        begin
            size_next = in_data.request_bytes;
            run_next  = '0;
            cap_next  = '0;
            if (in_data.operation == OP_ALLOC)
            begin
                idx_next   = '0;
                start_next = '0;
            end
            else
            begin
                idx_next   = CNT_W'(fs_idx);
                start_next = fs_idx;
            end
        end
        if (cmd.clr_step)
        begin
            mem_we   = 1'b1;
            idx_next = idx_reg + CNT_W'(1);
        end
        if (cmd.scan_step)
        begin
            if (!rd_valid)
            begin
                run_next = run_inc;
                cap_next = cap_add;
                if (run_reg == '0)
                begin
                    start_next = idx_reg[IDX_W-1:0];
                end
            end
            else
            begin
                run_next = '0;
                cap_next = '0;
            end
            if (!scan_fit)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
        // mark runs downward from the fitting bucket to the run start
        if (cmd.mark_step)
        begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, start_reg};
            if (idx_reg[IDX_W-1:0] != start_reg)
            begin
                idx_next = idx_reg - CNT_W'(1);
            end
        end
        if (cmd.free_step && free_match)
        begin
            mem_we   = 1'b1;
            run_next = run_inc;
            idx_next = idx_reg + CNT_W'(1);
        end
        if (cmd.calc_addr)
        begin
            prod_next = PROD_W'(start_reg) * PROD_W'(bb_reg);
        end
        if (cmd.set_status)
        begin
            status_next = cmd.status_code;
        end
    end

    // result register load and drain
    always_comb
    begin
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next       = 1'b1;
            out_item_next.status = status_reg;
            if (status_reg == ST_OK)
            begin
                out_item_next.start_bucket  = START_W'(start_reg);
                out_item_next.address       = base_reg + ADDR_W'(prod_reg);
                out_item_next.buckets_taken = COUNT_W'(run_reg);
            end
            else
            begin
                out_item_next.start_bucket  = '0;
                out_item_next.address       = '0;
                out_item_next.buckets_taken = '0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bb_reg        <= BB_RESET;
            base_reg      <= BASE_RESET;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bb_reg        <= bb_next;
            base_reg      <= base_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        run_reg      <= run_next;
        cap_reg      <= cap_next;
        start_reg    <= start_next;
        size_reg     <= size_next;
        status_reg   <= status_next;
        prod_reg     <= prod_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    `ASSERT_IMPLIES(a_mark_in_run, clk, rst_n, cmd.mark_step, idx_reg >= CNT_W'(start_reg), "mark below run start")
    `ASSERT_IMPLIES(a_ok_nonempty, clk, rst_n, cmd.out_load && (status_reg == ST_OK), run_reg != '0, "ok result with empty run")

endmodule

>>> rtl/contiguous_bucket_allocator.sv
// Usage notes
// First-fit allocator of contiguous bucket runs over NUM_BUCKETS buckets.
// Request channel in_valid/in_ready/in_data: operation 0 allocates
// request_bytes, operation 1 frees the run starting at free_start.
// Result channel out_valid/out_ready/out_data: one beat per request with
// status, start_bucket, address and buckets_taken; fields are zero unless ok.
// Config port cfg_we/cfg_index/cfg_data: index 0 bucket_bytes, 1 region_base;
// write only while no request is in flight.
// After reset the owner map is swept clear, one bucket per cycle, so
// in_ready stays low until the whole row is clear.
// One request at a time, paced by the single map port: an allocate scans
// from bucket zero to the first fitting free run, marks it and computes its
// address, or reports no room after the last bucket; a free releases buckets
// from free_start while that run owns them. Zero size and out of range frees
// skip the map, and a free of a bucket that starts no run reports not found.
// The result sits in an output register; a stalled receiver holds the
// block in its final step until the beat is taken.
module contiguous_bucket_allocator #(
    parameter int NUM_BUCKETS = cba_pkg::NUM_BUCKETS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cba_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cba_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cba_pkg::out_item_t             out_data
);
    import cba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    cba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // map, counters and result register
    cba_datapath #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> bench/contiguous_bucket_allocator_test.sv
// self-checking testbench for the contiguous bucket allocator
module contiguous_bucket_allocator_test;
    import cba_pkg::*;

    localparam int NB           = NUM_BUCKETS_DEF;
    // longest quiet stretch: reset sweep or a full two-pass allocate, plus stalls
    localparam int WATCH_LIMIT  = 8 * (2 * NB + 3) + 64;
    localparam int SETTLE       = 2 * NB + 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int NUM_PHASES   = 7;
    localparam int MAX_REPORTS  = 200;

    // predicts every result from its own copy of the owner map and registers
    class allocation_tracker;
        bit                taken[NB];
        int unsigned       owner[NB];
        logic [BB_W-1:0]   bucket_bytes;
        logic [ADDR_W-1:0] region_base;
        out_item_t         pending_results[$];
        int unsigned       mismatches;
        int unsigned       requests;
        int unsigned       granted;
        int unsigned       released;
        int unsigned       no_room;
        int unsigned       not_found;
        int unsigned       zero_size;

        function new();
            bucket_bytes = BB_RESET;
            region_base  = BASE_RESET;
            foreach (taken[i])
            begin
                taken[i] = 1'b0;
                owner[i] = 0;
            end
            mismatches = 0;
            requests   = 0;
            granted    = 0;
            released   = 0;
            no_room    = 0;
            not_found  = 0;
            zero_size  = 0;
        endfunction

        function void set_config(logic [BB_W-1:0] bb, logic [ADDR_W-1:0] base);
            bucket_bytes = bb;
            region_base  = base;
        endfunction

        // work out the result of an accepted request and update the map
        function void note_request(in_item_t req);
            out_item_t   res;
            int unsigned first;
            int unsigned run;
            int unsigned idx;
            int unsigned count;
            bit          fit;
            res   = '0;
            first = 0;
            run   = 0;
            count = 0;
            fit   = 1'b0;
            requests++;
            if (req.operation == OP_ALLOC)
            begin
                if (req.request_bytes == '0)
                begin
                    res.status = ST_ZERO;
                    zero_size++;
                end
                else
                begin
                    // first-fit scan from bucket zero
                    for (idx = 0; idx < NB && !fit; idx++)
                    begin
                        if (taken[idx])
                            run = 0;
                        else
                        begin
                            if (run == 0)
                                first = idx;
                            run++;
                        end
                        if (run != 0 && run * bucket_bytes >= req.request_bytes)
                            fit = 1'b1;
                    end
                    if (fit)
                    begin
                        for (idx = first; idx < first + run; idx++)
                        begin
                            taken[idx] = 1'b1;
                            owner[idx] = first;
                        end
                        res.status        = ST_OK;
                        res.start_bucket  = START_W'(first);
                        res.address       = region_base + first * bucket_bytes;
                        res.buckets_taken = COUNT_W'(run);
                        granted++;
                    end
                    else
                    begin
                        res.status = ST_NO_ROOM;
                        no_room++;
                    end
                end
            end
            else
            begin
                idx = req.free_start;
                if (idx >= NB || !taken[idx] || owner[idx] != idx)
                begin
                    res.status = ST_NOT_FOUND;
                    not_found++;
                end
                else
                begin
                    // release the run while it stays owned by its start
                    first = idx;
                    while (idx < NB && taken[idx] && owner[idx] == first)
                    begin
                        taken[idx] = 1'b0;
                        owner[idx] = 0;
                        count++;
                        idx++;
                    end
                    res.status        = ST_OK;
                    res.start_bucket  = START_W'(first);
                    res.address       = region_base + first * bucket_bytes;
                    res.buckets_taken = COUNT_W'(count);
                    released++;
                end
            end
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // compare a result beat against the oldest prediction
        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result expected none actual %p", $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("start_bucket", 32'(want.start_bucket), 32'(got.start_bucket));
            compare_field("address", want.address, got.address);
            compare_field("buckets_taken", 32'(want.buckets_taken), 32'(got.buckets_taken));
        endfunction

        // a random start bucket of a live run, or -1 when the map is empty
        function int owned_start();
            int starts[$];
            foreach (taken[i])
                if (taken[i] && owner[i] == i)
                    starts.push_back(i);
            if (starts.size() == 0)
                return -1;
            return starts[$urandom_range(0, starts.size() - 1)];
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BUCKET_BYTES;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;

    bit                steady        = 1'b0;
    int unsigned       quiet_cycles  = 0;
    int unsigned       settings_used = 1;
    allocation_tracker tracker;

    contiguous_bucket_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int unsigned draw_wait();
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    // request builders; the field a request ignores gets random bits
    function automatic in_item_t alloc_req(logic [SIZE_W-1:0] size);
        in_item_t req;
        req.operation     = OP_ALLOC;
        req.request_bytes = size;
        req.free_start    = FS_W'($urandom);
        return req;
    endfunction

    function automatic in_item_t free_req(logic [FS_W-1:0] start);
        in_item_t req;
        req.operation     = OP_FREE;
        req.request_bytes = SIZE_W'($urandom);
        req.free_start    = start;
        return req;
    endfunction

    // mostly allocations sized to the bucket, frees of live runs, some noise
    function automatic in_item_t random_request();
        int unsigned pick;
        int unsigned span;
        int          start;
        pick = $urandom_range(0, 99);
        span = tracker.bucket_bytes;
        if (pick < 55)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                return alloc_req('0);
            if (pick < 10)
                return alloc_req(SIZE_W'($urandom));
            if (pick < 22)
                return alloc_req(SIZE_W'($urandom_range(1, span * 48 + 1)));
            return alloc_req(SIZE_W'($urandom_range(1, span * 4 + 1)));
        end
        if (pick < 85)
        begin
            start = tracker.owned_start();
            if (start >= 0)
                return free_req(FS_W'(start));
        end
        return free_req(FS_W'($urandom_range(0, NB - 1)));
    endfunction

    // drive one request beat and hold it until accepted
    task automatic send_request(input in_item_t req);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_ready !== 1'b1);
        tracker.note_request(req);
    endtask

    // write both registers once the block has drained
    task automatic apply_config(input logic [BB_W-1:0] bb, input logic [ADDR_W-1:0] base);
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BUCKET_BYTES;
        cfg_data  <= CFG_DATA_W'(bb);
        @(posedge clk);
        cfg_index <= REG_REGION_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_config(bb, base);
        settings_used++;
    endtask

    // result side: random stalls, then take and check one beat
    initial
    begin
        int unsigned stall;
        forever
        begin
            stall = draw_wait();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1));
            tracker.check_result(out_data);
        end
    end

    // watchdog on cycles in which no beat moves
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCH_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [BB_W-1:0]   phase_bb[NUM_PHASES];
        logic [ADDR_W-1:0] phase_base[NUM_PHASES];
        int unsigned       p;
        int unsigned       k;
        tracker    = new();
        phase_bb   = '{13'd1, 13'd4096, 13'd0, 13'd64, 13'd13, 13'd4096, 13'd100};
        phase_base = '{32'h0000_0000, 32'hFFFF_F000, 32'h1234_5678, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero size, empty map, first fit, non-start free
        send_request(alloc_req('0));
        send_request(free_req(8'd0));
        send_request(free_req(8'd255));
        send_request(alloc_req(21'd1));
        send_request(alloc_req(21'd64));
        send_request(alloc_req(21'd65));
        send_request(free_req(8'd3));
        send_request(alloc_req(21'd1048576));
        send_request(alloc_req(21'h1F_FFFF));
        send_request(free_req(8'd1));
        send_request(alloc_req(21'd128));
        send_request(alloc_req(21'd50));
        send_request(free_req(8'd0));
        send_request(free_req(8'd1));
        send_request(free_req(8'd2));
        send_request(free_req(8'd4));

        // largest buckets: the whole row in one run, address at the top
        apply_config(13'd4096, 32'hFFFF_FFFF);
        send_request(alloc_req(21'd1048576));
        send_request(alloc_req(21'd1));
        send_request(free_req(8'd255));
        send_request(free_req(8'd0));

        // zero bucket size never fits
        apply_config(13'd0, 32'h0000_1000);
        send_request(alloc_req(21'd1));
        send_request(alloc_req('0));
        send_request(free_req(8'd0));

        // random phases over several register settings
        for (p = 0; p < NUM_PHASES; p++)
        begin
            apply_config(phase_bb[p], phase_base[p]);
            steady = (p % 3 == 1);
            for (k = 0; k < RANDOM_ITEMS / NUM_PHASES; k++)
                send_request(random_request());
        end
        steady = 1'b0;

        // drain and let the block settle
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (tracker.pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, tracker.pending_results.size());
            tracker.mismatches += tracker.pending_results.size();
        end
        $display("ran %0d requests under %0d register settings", tracker.requests,
                 settings_used);
        $display("granted %0d, released %0d, no room %0d, not found %0d, zero size %0d",
                 tracker.granted, tracker.released, tracker.no_room, tracker.not_found,
                 tracker.zero_size);
        if (tracker.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> contiguous_bucket_allocator.f
+incdir+rtl
rtl/cba_pkg.sv
rtl/cba_ram.sv
rtl/cba_ctrl.sv
rtl/cba_datapath.sv
rtl/contiguous_bucket_allocator.sv
bench/contiguous_bucket_allocator_test.sv
